// ===== rtl/nand_page_read_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// NAND page read sequencer assertion macros
// Concurrent check macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NAND_PAGE_READ_SEQUENCER_CORE_ASSERT_SVH
`define NAND_PAGE_READ_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTH

`define NPR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define NPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NPR_ASSERT(lbl, expr, msg)

`define NPR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/npr_pkg.sv =====
// ----------------------------------------------------------------------------
// NAND page read sequencer package
// Shared codes, job descriptor and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npr_pkg;

    localparam int unsigned DEFAULT_PAGE_BYTES = 2048;
    localparam int unsigned QUEUE_DEPTH        = 4;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_POLL  = 2'd1;
    localparam logic [1:0] FUNC_DATA  = 2'd2;

    localparam logic [2:0] OP_SELECT   = 3'd0;
    localparam logic [2:0] OP_CMD      = 3'd1;
    localparam logic [2:0] OP_ADDR     = 3'd2;
    localparam logic [2:0] OP_STORE    = 3'd3;
    localparam logic [2:0] OP_DESELECT = 3'd4;

    localparam logic [7:0] CMD_READ         = 8'h00;
    localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        JOB_START_ZERO = 3'd0,
        JOB_START_SEQ  = 3'd1,
        JOB_STORE      = 3'd2,
        JOB_STORE_END  = 3'd3,
        JOB_STORE_SEQ  = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic [31:0] index;
        logic [31:0] address;
    } job_t;

endpackage

// ===== rtl/npr_if.sv =====
// ----------------------------------------------------------------------------
// NAND page read sequencer channels
// Valid/ready channels for request items and bus results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] start_address;
    logic [31:0] length;
    logic        ready_req;
    logic [7:0]  flash_byte;

    modport source (output valid, func, start_address, length, ready_req, flash_byte,
                    input ready);
    modport sink   (input valid, func, start_address, length, ready_req, flash_byte,
                    output ready);
endinterface

interface npr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  bus_byte;
    logic [31:0] buffer_index;
    logic        last;

    modport source (output valid, op, bus_byte, buffer_index, last, input ready);
    modport sink   (input valid, op, bus_byte, buffer_index, last, output ready);
endinterface

// ===== rtl/npr_front.sv =====
// ----------------------------------------------------------------------------
// NAND page read sequencer front end
// Accepts request items, tracks read phase and progress, and queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npr_front #(
    parameter int unsigned PAGE_BYTES = npr_pkg::DEFAULT_PAGE_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    npr_in_if.sink         item,
    input  logic           q_full,
    output logic           push,
    output npr_pkg::job_t  push_job
);
    import npr_pkg::*;

    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

    phase_t      phase_reg, phase_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] total_reg, total_next;
    logic        accept;
    logic        has_job;
    logic [31:0] addr_inc;
    logic [31:0] done_inc;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign addr_inc   = addr_reg + 32'd1;
    assign done_inc   = done_reg + 32'd1;
    assign push       = accept && has_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            done_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
            total_reg <= total_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        addr_next         = addr_reg;
        done_next         = done_reg;
        total_next        = total_reg;
        has_job           = 1'b0;
        push_job.kind     = JOB_STORE;
        push_job.data     = item.flash_byte;
        push_job.index    = done_reg;
        push_job.address  = addr_inc;
        if (accept)
        begin
            priority if (item.func == FUNC_START && phase_reg == PH_IDLE)
            begin
                has_job = 1'b1;
                if (item.length == 32'd0)
                begin
                    push_job.kind = JOB_START_ZERO;
                end
                else
                begin
                    push_job.kind    = JOB_START_SEQ;
                    push_job.address = item.start_address;
                    addr_next        = item.start_address;
                    done_next        = '0;
                    total_next       = item.length;
                    phase_next       = PH_WAIT;
                end
            end
            else if (item.func == FUNC_POLL && phase_reg == PH_WAIT)
            begin
                if (item.ready_req)
                    phase_next = PH_DATA;
            end
            else if (item.func == FUNC_DATA && phase_reg == PH_DATA)
            begin
                has_job   = 1'b1;
                addr_next = addr_inc;
                done_next = done_inc;
                if (done_inc == total_reg)
                begin
                    push_job.kind = JOB_STORE_END;
                    phase_next    = PH_IDLE;
                end
                else if (addr_inc[PAGE_SHIFT-1:0] == '0)
                begin
                    push_job.kind = JOB_STORE_SEQ;
                    phase_next    = PH_WAIT;
                end
            end
            else
            begin
                has_job = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/npr_queue.sv =====
// ----------------------------------------------------------------------------
// NAND page read sequencer job queue
// Small FIFO of job descriptors between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npr_queue #(
    parameter int unsigned DEPTH = npr_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npr_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output npr_pkg::job_t  head_job
);
    import npr_pkg::*;

    `include "nand_page_read_sequencer_core_assert.svh"

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full       = cnt_reg == (AW+1)'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + (AW+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    `NPR_ASSERT(a_no_overflow, !(push && full), "job pushed into full queue")
    `NPR_ASSERT(a_no_underflow, !(pop && !head_valid), "job popped from empty queue")
    `NPR_ASSERT(a_cnt_range, cnt_reg <= (AW+1)'(DEPTH), "queue count out of range")

endmodule

// ===== rtl/npr_back.sv =====
// ----------------------------------------------------------------------------
// NAND page read sequencer back end
// Expands queued jobs into bus results, one per cycle unless result.ready stalls the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npr_back #(
    parameter int unsigned PAGE_BYTES = npr_pkg::DEFAULT_PAGE_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  npr_pkg::job_t  head_job,
    output logic           pop,
    npr_out_if.source      result
);
    import npr_pkg::*;

    `include "nand_page_read_sequencer_core_assert.svh"

    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  op_reg;
    logic [7:0]  byte_reg;
    logic [31:0] index_reg;
    logic        last_reg;

    logic        load;
    logic [2:0]  final_step;
    logic        last_res;
    logic [2:0]  res_op;
    logic [7:0]  res_byte;
    logic [31:0] res_index;
    logic [15:0] col16;
    logic [31:0] page;

    assign col16 = 16'(head_job.address[PAGE_SHIFT-1:0]);
    assign page  = head_job.address >> PAGE_SHIFT;

    always_comb
    begin
        unique case (head_job.kind)
            JOB_STORE:                      final_step = 3'd0;
            JOB_START_ZERO, JOB_STORE_END:  final_step = 3'd1;
            default:                        final_step = 3'd7;
        endcase
    end

    always_comb
    begin
        res_op    = OP_DESELECT;
        res_byte  = '0;
        res_index = '0;
        if (step_reg == 3'd0)
        begin
            if (head_job.kind == JOB_START_ZERO || head_job.kind == JOB_START_SEQ)
            begin
                res_op = OP_SELECT;
            end
            else
            begin
                res_op    = OP_STORE;
                res_byte  = head_job.data;
                res_index = head_job.index;
            end
        end
        else if (head_job.kind == JOB_START_SEQ || head_job.kind == JOB_STORE_SEQ)
        begin
            res_op = OP_ADDR;
            unique case (step_reg)
                3'd1:
                begin
                    res_op   = OP_CMD;
                    res_byte = CMD_READ;
                end
                3'd2:    res_byte = col16[7:0];
                3'd3:    res_byte = col16[15:8];
                3'd4:    res_byte = page[7:0];
                3'd5:    res_byte = page[15:8];
                3'd6:    res_byte = page[23:16];
                default:
                begin
                    res_op   = OP_CMD;
                    res_byte = CMD_READ_CONFIRM;
                end
            endcase
        end
    end

    assign last_res = step_reg == final_step;
    assign load     = head_valid && (!out_valid_reg || result.ready);
    assign pop      = load && last_res;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = last_res ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= res_op;
            byte_reg  <= res_byte;
            index_reg <= res_index;
            last_reg  <= last_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.op           = op_reg;
    assign result.bus_byte     = byte_reg;
    assign result.buffer_index = index_reg;
    assign result.last         = last_reg;

    `NPR_ASSERT(a_step_bound, !head_valid || step_reg <= final_step,
                "result step past end of job")
    `NPR_ASSERT(a_idle_step, head_valid || step_reg == 3'd0,
                "step counter not at zero without a job")
    `NPR_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_reg && last_reg,
                     "job retired without last result")

endmodule

// ===== rtl/nand_page_read_sequencer_core.sv =====
// The first result of an item passes the job queue, then the output register; result.ready
// can stall it. Items are accepted one per cycle while the job queue (depth 4) is not full.
// The back end drives one result per cycle unless result.ready stalls it; a data byte gives
// 1 result, a last byte 2, a page end 8, a start 2 or 8.
// Reset: rst_n asynchronous, active low; phase idle, counters cleared, queue and output empty.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
// NAND page read sequencer core
// Front end classifies requests, job queue decouples, back end drives the bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nand_page_read_sequencer_core #(
    parameter int unsigned PAGE_BYTES = npr_pkg::DEFAULT_PAGE_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    npr_in_if.sink    item,
    npr_out_if.source result
);
    import npr_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    npr_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    npr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    npr_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule
